/* rtl/ppcb_pkg.sv */
// shared types and constants for the point-op and cross-blur core
`default_nettype none
package ppcb_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;
  localparam int unsigned PIXEL_BITS     = 16;

  localparam int unsigned PIX_W   = 17;
  localparam int unsigned MAXV_W  = 16;
  localparam int unsigned GEOM_W  = 11;
  localparam int unsigned CIDX_W  = 8;
  localparam int unsigned CDATA_W = 16;

  localparam logic [MAXV_W-1:0] PIX_LIM =
    MAXV_W'((64'd1 << PIXEL_BITS) - 64'd1);

  // register indexes on the config port
  localparam logic [CIDX_W-1:0] REG_MODE   = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_MAXV   = CIDX_W'(1);
  localparam logic [CIDX_W-1:0] REG_WIDTH  = CIDX_W'(2);
  localparam logic [CIDX_W-1:0] REG_HEIGHT = CIDX_W'(3);

  // mode codes
  localparam logic [1:0] MODE_BRIGHT = 2'd0;
  localparam logic [1:0] MODE_DOUBLE = 2'd1;
  localparam logic [1:0] MODE_HALVE  = 2'd2;
  localparam logic [1:0] MODE_BLUR   = 2'd3;

  localparam logic [1:0]        MODE_RST   = MODE_BLUR;
  localparam logic [MAXV_W-1:0] MAXV_RST   = MAXV_W'(255);
  localparam int unsigned       IMG_W_RST  = 640;
  localparam int unsigned       IMG_H_RST  = 480;
  localparam logic [MAXV_W-1:0] BRIGHT_ADD = MAXV_W'(50);

  // req_type codes
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // divide by 5: (m * DIV5_MUL) >> DIV5_SHIFT is exact for m < 2^19
  localparam int unsigned SUM_W      = 20;
  localparam int unsigned MAG_W      = 19;
  localparam int unsigned PROD_W     = 38;
  localparam int unsigned DIV5_SHIFT = 21;
  localparam logic [MAG_W-1:0] DIV5_MUL = MAG_W'(419431);

  localparam int unsigned OFIFO_DEPTH = 8;
  localparam int unsigned OFIFO_AW    = 3;

  // per-item control decided at accept time
  typedef struct packed {
    logic pix;   // pixel item, writes the line store
    logic emit;  // item produces a result
    logic blur;  // result is the cross mean
    logic last;  // result closes the frame
  } item_ctl_t;

  typedef struct packed {
    logic                    last;
    logic signed [PIX_W-1:0] pixel;
  } out_item_t;

endpackage
`default_nettype wire

/* rtl/ppcb_ctrl.sv */
// config registers, point operation and stream position counters
`default_nettype none
module ppcb_ctrl #(
  parameter int unsigned MAX_WIDTH  = ppcb_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = ppcb_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [ppcb_pkg::CIDX_W-1:0]          cfg_index_i,
  input  wire logic [ppcb_pkg::CDATA_W-1:0]         cfg_data_i,
  input  wire logic                                 acc_i,
  input  wire logic                                 req_type_i,
  input  wire logic signed [ppcb_pkg::PIX_W-1:0]    pixel_in_i,
  output ppcb_pkg::item_ctl_t                       ctl_o,
  output logic [$clog2(MAX_WIDTH)-1:0]              wr_addr_o,
  output logic [$clog2(MAX_WIDTH)-1:0]              rd_addr_o,
  output logic signed [ppcb_pkg::PIX_W-1:0]         pix_val_o
);
  import ppcb_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HAW = $clog2(MAX_HEIGHT);
  localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned W_RST = (IMG_W_RST > MAX_WIDTH) ? MAX_WIDTH : IMG_W_RST;
  localparam int unsigned H_RST = (IMG_H_RST > MAX_HEIGHT) ? MAX_HEIGHT : IMG_H_RST;

  logic [1:0]        mode_q, mode_d;
  logic [MAXV_W-1:0] mx_q, mx_d;
  logic [WW-1:0]     w_q, w_d;
  logic [HW-1:0]     h_q, h_d;
  logic [AW-1:0]     wa_q, wa_d;
  logic [WW-1:0]     pend_q, pend_d;
  logic [AW-1:0]     col_q, col_d;
  logic [HAW-1:0]    row_q, row_d;

  logic              cfg_hit;
  logic              is_pix, emit, col_end, row_end, blur;
  logic [AW-1:0]     wa_nx;
  logic [WW-1:0]     diff;
  logic [WW-1:0]     drain_addr;
  logic              invalid;
  logic [MAXV_W:0]   sum_b, dbl;
  logic [MAXV_W-1:0] pv;

  // point operation
  always_comb begin
    invalid = pixel_in_i[PIX_W-1] | (pixel_in_i[MAXV_W-1:0] > mx_q);
    sum_b   = {1'b0, pixel_in_i[MAXV_W-1:0]} + {1'b0, BRIGHT_ADD};
    dbl     = {pixel_in_i[MAXV_W-1:0], 1'b0};
    case (mode_q)
      MODE_BRIGHT: pv = (sum_b > {1'b0, mx_q}) ? mx_q : sum_b[MAXV_W-1:0];
      MODE_DOUBLE: pv = (dbl > {1'b0, mx_q}) ? mx_q : dbl[MAXV_W-1:0];
      MODE_HALVE:  pv = {1'b0, pixel_in_i[MAXV_W-1:1]};
      default:     pv = pixel_in_i[MAXV_W-1:0];
    endcase
    pix_val_o = invalid ? '1 : {1'b0, pv};
  end

  always_comb begin
    cfg_hit = cfg_we_i && (cfg_index_i == REG_MODE || cfg_index_i == REG_MAXV ||
                           cfg_index_i == REG_WIDTH || cfg_index_i == REG_HEIGHT);
    is_pix  = (req_type_i == REQ_PIXEL);
    col_end = ({1'b0, col_q} == w_q - WW'(1));
    row_end = ({1'b0, row_q} == h_q - HW'(1));
    emit    = is_pix ? (pend_q == w_q) : (pend_q != '0);
    blur    = is_pix && (mode_q == MODE_BLUR) && (row_q != '0) && !row_end &&
              (col_q != '0) && !col_end;
    wa_nx   = ({1'b0, wa_q} == w_q - WW'(1)) ? '0 : wa_q + AW'(1);
    // oldest pending sample sits pend places behind the write pointer
    diff       = {1'b0, wa_q} - pend_q;
    drain_addr = ({1'b0, wa_q} >= pend_q) ? diff : diff + w_q;

    ctl_o.pix  = is_pix;
    ctl_o.emit = emit;
    ctl_o.blur = blur;
    ctl_o.last = row_end && col_end;
    wr_addr_o  = wa_q;
    rd_addr_o  = is_pix ? wa_nx : drain_addr[AW-1:0];
  end

  always_comb begin
    mode_d = mode_q;
    mx_d   = mx_q;
    w_d    = w_q;
    h_d    = h_q;
    wa_d   = wa_q;
    pend_d = pend_q;
    col_d  = col_q;
    row_d  = row_q;
    if (cfg_hit) begin
      case (cfg_index_i)
        REG_MODE: mode_d = cfg_data_i[1:0];
        REG_MAXV: mx_d = (cfg_data_i > PIX_LIM) ? PIX_LIM : cfg_data_i;
        REG_WIDTH: begin
          if (cfg_data_i[GEOM_W-1:0] == '0) w_d = WW'(1);
          else if (32'(cfg_data_i[GEOM_W-1:0]) > MAX_WIDTH) w_d = WW'(MAX_WIDTH);
          else w_d = WW'(cfg_data_i[GEOM_W-1:0]);
        end
        default: begin
          if (cfg_data_i[GEOM_W-1:0] == '0) h_d = HW'(1);
          else if (32'(cfg_data_i[GEOM_W-1:0]) > MAX_HEIGHT) h_d = HW'(MAX_HEIGHT);
          else h_d = HW'(cfg_data_i[GEOM_W-1:0]);
        end
      endcase
      wa_d   = '0;
      pend_d = '0;
      col_d  = '0;
      row_d  = '0;
    end else if (acc_i) begin
      if (is_pix) begin
        wa_d = wa_nx;
        if (!emit) pend_d = pend_q + WW'(1);
      end else if (emit) begin
        pend_d = pend_q - WW'(1);
      end
      if (emit) begin
        if (row_end && col_end) begin
          col_d = '0;
          row_d = '0;
        end else if (col_end) begin
          col_d = '0;
          row_d = row_q + HAW'(1);
        end else begin
          col_d = col_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RST;
      mx_q   <= MAXV_RST;
      w_q    <= WW'(W_RST);
      h_q    <= HW'(H_RST);
      wa_q   <= '0;
      pend_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      mode_q <= mode_d;
      mx_q   <= mx_d;
      w_q    <= w_d;
      h_q    <= h_d;
      wa_q   <= wa_d;
      pend_q <= pend_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/ppcb_line_mem.sv */
// two cascaded line memories holding the last two rows of processed samples
`default_nettype none
module ppcb_line_mem #(
  parameter int unsigned MAX_WIDTH = ppcb_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               acc_i,
  input  wire logic                               pix_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]       wr_addr_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]       rd_addr_i,
  input  wire logic signed [ppcb_pkg::PIX_W-1:0]  pix_val_i,
  output logic signed [ppcb_pkg::PIX_W-1:0]       cen_o,
  output logic signed [ppcb_pkg::PIX_W-1:0]       oth_o,
  output logic signed [ppcb_pkg::PIX_W-1:0]       up_o
);
  import ppcb_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic signed [PIX_W-1:0] mem_a [MAX_WIDTH];
  logic signed [PIX_W-1:0] mem_b [MAX_WIDTH];
  logic signed [PIX_W-1:0] cen_q, oth_q, up_q;
  logic                    s1_pix_q;
  logic [AW-1:0]           s1_addr_q;

  // row memory: read-first, the old entry at the write address is one row back
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      cen_q <= mem_a[wr_addr_i];
      oth_q <= mem_a[rd_addr_i];
      if (pix_i) mem_a[wr_addr_i] <= pix_val_i;
    end
  end

  // second row memory takes what falls out of the first in the next cycle
  always_ff @(posedge clk_i) begin
    if (acc_i) up_q <= mem_b[wr_addr_i];
    if (s1_pix_q) mem_b[s1_addr_q] <= cen_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_pix_q <= 1'b0;
    end else begin
      s1_pix_q <= acc_i & pix_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= wr_addr_i;
  end

  assign cen_o = cen_q;
  assign oth_o = oth_q;
  assign up_o  = up_q;

endmodule
`default_nettype wire

/* rtl/ppcb_cross_mean.sv */
// cross sum, divide by five and result select, three pipeline stages
`default_nettype none
module ppcb_cross_mean (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               acc_i,
  input  ppcb_pkg::item_ctl_t                     ctl_i,
  input  wire logic signed [ppcb_pkg::PIX_W-1:0]  pix_val_i,
  input  wire logic signed [ppcb_pkg::PIX_W-1:0]  cen_i,
  input  wire logic signed [ppcb_pkg::PIX_W-1:0]  oth_i,
  input  wire logic signed [ppcb_pkg::PIX_W-1:0]  up_i,
  output logic                                    push_o,
  output ppcb_pkg::out_item_t                     push_data_o,
  output logic [1:0]                              inflight_o
);
  import ppcb_pkg::*;

  logic                    s1_v_q;
  item_ctl_t               s1_ctl_q;
  logic signed [PIX_W-1:0] down_q, left_q;
  logic signed [SUM_W-1:0] sum1;

  logic                    s2_v_q, s2_blur_q, s2_last_q;
  logic signed [SUM_W-1:0] s2_sum_q;
  logic signed [PIX_W-1:0] s2_val_q;
  logic [SUM_W-1:0]        mag20;
  logic [PROD_W-1:0]       prod;

  logic                    s3_v_q, s3_blur_q, s3_last_q, s3_neg_q;
  logic [PROD_W-1:0]       s3_prod_q;
  logic signed [PIX_W-1:0] s3_val_q;
  logic [PIX_W-1:0]        quo, res;

  assign sum1 = SUM_W'(cen_i) + SUM_W'(left_q) + SUM_W'(oth_i) + SUM_W'(up_i) +
                SUM_W'(down_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= acc_i;
      s2_v_q <= s1_v_q & s1_ctl_q.emit;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_ctl_q <= ctl_i;
      down_q   <= pix_val_i;
    end
    // left neighbour is the centre seen by the previous pixel item
    if (s1_v_q && s1_ctl_q.pix) left_q <= cen_i;
    s2_sum_q  <= sum1;
    s2_val_q  <= s1_ctl_q.pix ? cen_i : oth_i;
    s2_blur_q <= s1_ctl_q.blur;
    s2_last_q <= s1_ctl_q.last;
    s3_prod_q <= prod;
    s3_neg_q  <= s2_sum_q[SUM_W-1];
    s3_val_q  <= s2_val_q;
    s3_blur_q <= s2_blur_q;
    s3_last_q <= s2_last_q;
  end

  always_comb begin
    mag20 = s2_sum_q[SUM_W-1] ? SUM_W'(-s2_sum_q) : SUM_W'(s2_sum_q);
    prod  = PROD_W'(mag20[MAG_W-1:0]) * PROD_W'(DIV5_MUL);
  end

  // truncation toward zero: divide the magnitude, restore the sign
  always_comb begin
    quo = s3_prod_q[DIV5_SHIFT +: PIX_W];
    res = s3_neg_q ? PIX_W'(-quo) : quo;
    push_o            = s3_v_q;
    push_data_o.last  = s3_last_q;
    push_data_o.pixel = s3_blur_q ? $signed(res) : s3_val_q;
    inflight_o = 2'(s1_v_q & s1_ctl_q.emit) + 2'(s2_v_q) + 2'(s3_v_q);
  end

endmodule
`default_nettype wire

/* rtl/ppcb_out_fifo.sv */
// result queue that decouples the output handshake from the pipeline
`default_nettype none
module ppcb_out_fifo (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  ppcb_pkg::out_item_t              push_data_i,
  input  wire logic                        pop_i,
  output logic                             valid_o,
  output ppcb_pkg::out_item_t              data_o,
  output logic [ppcb_pkg::OFIFO_AW:0]      count_o
);
  import ppcb_pkg::*;

  out_item_t           buf_q [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0] wp_q, rp_q;
  logic [OFIFO_AW:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + OFIFO_AW'(1);
      if (pop_i) rp_q <= rp_q + OFIFO_AW'(1);
      cnt_q <= cnt_q + (OFIFO_AW+1)'(push_i) - (OFIFO_AW+1)'(pop_i);
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rp_q];
  assign count_o = cnt_q;

endmodule
`default_nettype wire

/* rtl/pixel_point_op_and_cross_blur_core.sv */
// top level of the point-op and five-point cross blur core
//
//   channel   dir  handshake                   payload
//   s_axis    in   s_axis_tvalid/tready        tdata[16:0] pixel_in, tuser[0] req_type
//   m_axis    out  m_axis_tvalid/tready        tdata[16:0] pixel_out, tlast frame_last
//   cfg       in   cfg_valid_i/cfg_ready_o     cfg_index_i register, cfg_data_i value
//
// one item per clock while s_axis_tready is high; a result reaches the queue after the
// line memory read, the cross sum and the divide multiplier registers.
// results trail the pixel stream by one row (image_width items); drain items flush them.
// reset restores the register defaults and empties the pipeline and the queue; the
// line memories are not cleared. s_axis_tready drops only when the 8-entry result
// queue together with the results in flight would overflow; cfg_ready_o is always high.
`default_nettype none
module pixel_point_op_and_cross_blur_core #(
  parameter int unsigned MAX_WIDTH  = ppcb_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = ppcb_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [23:0]                       s_axis_tdata,  // [16:0] pixel_in
  input  wire logic [0:0]                        s_axis_tuser,  // [0] req_type
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [23:0]                            m_axis_tdata,  // [16:0] pixel_out
  output logic                                   m_axis_tlast,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [ppcb_pkg::CIDX_W-1:0]       cfg_index_i,
  input  wire logic [ppcb_pkg::CDATA_W-1:0]      cfg_data_i
);
  import ppcb_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic                    acc;
  item_ctl_t               ctl;
  logic [AW-1:0]           wr_addr, rd_addr;
  logic signed [PIX_W-1:0] pix_val, cen, oth, up;
  logic                    push;
  out_item_t               push_data, head;
  logic [1:0]              inflight;
  logic [OFIFO_AW:0]       fcount;
  logic [OFIFO_AW+1:0]     busy;

  assign busy          = (OFIFO_AW+2)'(fcount) + (OFIFO_AW+2)'(inflight);
  assign s_axis_tready = (busy < (OFIFO_AW+2)'(OFIFO_DEPTH));
  assign acc           = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  ppcb_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .acc_i       (acc),
    .req_type_i  (s_axis_tuser[0]),
    .pixel_in_i  ($signed(s_axis_tdata[PIX_W-1:0])),
    .ctl_o       (ctl),
    .wr_addr_o   (wr_addr),
    .rd_addr_o   (rd_addr),
    .pix_val_o   (pix_val)
  );

  ppcb_line_mem #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .pix_i     (ctl.pix),
    .wr_addr_i (wr_addr),
    .rd_addr_i (rd_addr),
    .pix_val_i (pix_val),
    .cen_o     (cen),
    .oth_o     (oth),
    .up_o      (up)
  );

  ppcb_cross_mean u_cross_mean (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .ctl_i       (ctl),
    .pix_val_i   (pix_val),
    .cen_i       (cen),
    .oth_i       (oth),
    .up_i        (up),
    .push_o      (push),
    .push_data_o (push_data),
    .inflight_o  (inflight)
  );

  ppcb_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (m_axis_tvalid & m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .data_o      (head),
    .count_o     (fcount)
  );

  assign m_axis_tdata = {7'b0, head.pixel};
  assign m_axis_tlast = head.last;

endmodule
`default_nettype wire

/* test/testbench.sv */
// self-checking testbench for the point-op and cross-blur core
module testbench;
  import ppcb_pkg::*;

  localparam int unsigned COLS_MAX     = 1024;
  localparam int unsigned ROWS_MAX     = 1024;
  localparam int unsigned LINE_SPAN    = 2 * COLS_MAX + 1;
  localparam int          LIFT         = 50;
  localparam int          RAND_ITEMS   = 1900;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          QUIET_LIMIT  = 2000;

  typedef enum logic [1:0] {STEP_CFG, STEP_ITEM, STEP_TYPED} step_kind_e;

  typedef struct packed {
    step_kind_e              kind;
    logic [CIDX_W-1:0]       idx;
    logic [CDATA_W-1:0]      data;
    logic                    req;
    logic signed [PIX_W-1:0] pix;
    out_item_t               want;
  } step_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata;   // [16:0] pixel_in
  logic [0:0]          s_axis_tuser;   // [0] req_type
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;   // [16:0] pixel_out
  logic                m_axis_tlast;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CIDX_W-1:0]   cfg_index_i;
  logic [CDATA_W-1:0]  cfg_data_i;

  // model of the block
  logic signed [PIX_W-1:0] line_ring [LINE_SPAN];
  int unsigned             ring_wr;
  int unsigned             held;
  int unsigned             raster_idx;
  logic [1:0]              op_mode;
  logic [15:0]             sat_max;
  logic [10:0]             cols_reg;
  logic [10:0]             rows_reg;

  out_item_t   due_q[$];
  step_t       plan[$];
  int          burst_left;
  bit          calm;
  int          rx_period = 5;
  int          rx_stall  = 2;
  int unsigned rx_tick   = 0;
  int          bad_count = 0;
  int          quiet_cycles = 0;
  int unsigned results_seen = 0;
  out_item_t   want_now;
  logic signed [PIX_W-1:0] got_px;

  pixel_point_op_and_cross_blur_core #(
    .MAX_WIDTH (COLS_MAX),
    .MAX_HEIGHT(ROWS_MAX)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned cols();
    if (cols_reg < 1) return 1;
    if (cols_reg > COLS_MAX) return COLS_MAX;
    return cols_reg;
  endfunction

  function automatic int unsigned rows();
    if (rows_reg < 1) return 1;
    if (rows_reg > ROWS_MAX) return ROWS_MAX;
    return rows_reg;
  endfunction

  function automatic logic signed [PIX_W-1:0] shade(input logic signed [PIX_W-1:0] raw);
    int p;
    int mx;
    int v;
    p  = raw;
    mx = sat_max;
    if (p < 0 || p > mx) return '1;
    case (op_mode)
      MODE_BRIGHT: v = (p + LIFT > mx) ? mx : p + LIFT;
      MODE_DOUBLE: v = (2 * p > mx) ? mx : 2 * p;
      MODE_HALVE:  v = p / 2;
      default:     v = p;
    endcase
    return v[PIX_W-1:0];
  endfunction

  // entry k places back from the newest one
  function automatic logic signed [PIX_W-1:0] ring_back(input int unsigned k);
    int unsigned newest;
    newest = (ring_wr + LINE_SPAN - 1) % LINE_SPAN;
    return line_ring[(newest + LINE_SPAN - (k % LINE_SPAN)) % LINE_SPAN];
  endfunction

  function automatic out_item_t release_oldest(input bit may_blur);
    int unsigned w;
    int unsigned h;
    int unsigned age;
    int unsigned row;
    int unsigned col;
    int          s;
    out_item_t   r;
    w = cols();
    h = rows();
    age = held - 1;
    row = raster_idx / w;
    col = raster_idx % w;
    r.pixel = ring_back(age);
    r.last  = (raster_idx >= w * h - 1);
    if (may_blur && op_mode == MODE_BLUR && row > 0 && row + 1 < h &&
        col > 0 && col + 1 < w) begin
      s = int'(r.pixel) + int'(ring_back(age - 1)) + int'(ring_back(age + 1)) +
          int'(ring_back(age + w)) + int'(ring_back(age - w));
      s = s / 5;
      r.pixel = s[PIX_W-1:0];
    end
    raster_idx = r.last ? 0 : raster_idx + 1;
    held--;
    return r;
  endfunction

  function automatic bit step_model(input logic req, input logic signed [PIX_W-1:0] raw,
                                    output out_item_t r);
    r = '0;
    if (req == REQ_DRAIN) begin
      if (held == 0) return 1'b0;
      r = release_oldest(1'b0);
      return 1'b1;
    end
    line_ring[ring_wr] = shade(raw);
    ring_wr = (ring_wr + 1) % LINE_SPAN;
    held++;
    if (held > cols()) begin
      r = release_oldest(1'b1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic signed [PIX_W-1:0] rand_pixel();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom_range(0, sat_max);
      5:             v = sat_max + $urandom_range(1, 3);
      6:             v = -int'($urandom_range(1, 4));
      7, 8:          v = $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0:       v = 0;
          1:       v = sat_max;
          2:       v = 65535;
          default: v = -65536;
        endcase
      end
    endcase
    return v[PIX_W-1:0];
  endfunction

  function automatic void put_cfg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    step_t s;
    s = '0;
    s.kind = STEP_CFG;
    s.idx  = idx;
    s.data = data;
    plan.push_back(s);
  endfunction

  function automatic void put_item(input logic req, input logic signed [PIX_W-1:0] pix);
    step_t s;
    s = '0;
    s.kind = STEP_ITEM;
    s.req  = req;
    s.pix  = pix;
    plan.push_back(s);
  endfunction

  function automatic void put_typed(input logic req, input logic signed [PIX_W-1:0] pix,
                                    input logic signed [PIX_W-1:0] want_px,
                                    input logic want_last);
    step_t s;
    s = '0;
    s.kind       = STEP_TYPED;
    s.req        = req;
    s.pix        = pix;
    s.want.pixel = want_px;
    s.want.last  = want_last;
    plan.push_back(s);
  endfunction

  task automatic flag(input string msg);
    bad_count++;
    if (bad_count <= 10) $display("%s", msg);
  endtask

  task automatic send(input logic req, input logic signed [PIX_W-1:0] pix,
                      input bit typed, input out_item_t want);
    out_item_t got;
    bit        made;
    int        gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (calm || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = req;
    s_axis_tdata  = {7'd0, pix};
    do @(posedge clk_i); while (!s_axis_tready);
    made = step_model(req, pix, got);
    if (typed) due_q.push_back(want);
    else if (made) due_q.push_back(got);
  endtask

  // stop sending and let every expected result come out
  task automatic wait_quiet();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    burst_left = 0;
    while (due_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MODE:   op_mode  = data[1:0];
      REG_MAXV:   sat_max  = data;
      REG_WIDTH:  cols_reg = data[10:0];
      REG_HEIGHT: rows_reg = data[10:0];
      default: ;
    endcase
    held = 0;
    raster_idx = 0;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic configure(input logic [15:0] m, input logic [15:0] mx,
                           input logic [15:0] w, input logic [15:0] h);
    wait_quiet();
    write_reg(REG_MODE, m);
    write_reg(REG_MAXV, mx);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic flush_held();
    while (held != 0) send(REQ_DRAIN, '0, 1'b0, '0);
  endtask

  // receiver stall pattern
  always @(negedge clk_i) begin
    rx_tick <= rx_tick + 1;
    m_axis_tready <= calm || ((rx_tick % rx_period) >= rx_stall);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_px = m_axis_tdata[PIX_W-1:0];
      results_seen++;
      if (due_q.size() == 0) begin
        flag($sformatf("result %0d: pixel %0d last %0b with nothing expected",
                       results_seen, got_px, m_axis_tlast));
      end else begin
        want_now = due_q.pop_front();
        if (got_px !== want_now.pixel)
          flag($sformatf("result %0d: pixel %0d, expected %0d",
                         results_seen, got_px, want_now.pixel));
        if (m_axis_tlast !== want_now.last)
          flag($sformatf("result %0d: last %0b, expected %0b",
                         results_seen, m_axis_tlast, want_now.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] junk;
    logic [15:0] mode_data;
    logic [15:0] max_data;
    logic [15:0] w_data;
    logic [15:0] h_data;
    int          w;
    int          h;
    int          n;
    int          rand_done;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    calm          = 1'b0;
    burst_left    = 0;
    rand_done     = 0;
    op_mode  = MODE_BLUR;
    sat_max  = 16'd255;
    cols_reg = 11'd640;
    rows_reg = 11'd480;
    ring_wr = 0;
    held = 0;
    raster_idx = 0;
    foreach (line_ring[i]) line_ring[i] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // register defaults: one row of 640 plus a few, values past 255 go invalid
    for (int i = 0; i < 644; i++) begin
      n = i;
      send(REQ_PIXEL, n[PIX_W-1:0], 1'b0, '0);
    end

    // directed part, width 1 so each item pushes out the one before
    put_cfg(REG_MODE, MODE_BRIGHT);
    put_cfg(REG_MAXV, 16'hFFFF);
    put_cfg(REG_WIDTH, 16'd1);
    put_cfg(REG_HEIGHT, 16'd1);
    put_item(REQ_PIXEL, 17'd0);
    put_typed(REQ_PIXEL, 17'd65535, 17'd50, 1'b1);
    put_typed(REQ_PIXEL, 17'h1FFFF, 17'd65535, 1'b1);
    put_typed(REQ_PIXEL, 17'h10000, 17'h1FFFF, 1'b1);
    put_typed(REQ_DRAIN, 17'd0, 17'h1FFFF, 1'b1);
    put_item(REQ_DRAIN, 17'd0);
    put_cfg(REG_MODE, MODE_DOUBLE);
    put_cfg(REG_MAXV, 16'd0);
    put_item(REQ_PIXEL, 17'd0);
    put_typed(REQ_PIXEL, 17'd1, 17'd0, 1'b1);
    put_typed(REQ_DRAIN, 17'd0, 17'h1FFFF, 1'b1);
    put_cfg(REG_MODE, MODE_HALVE);
    put_cfg(REG_MAXV, 16'hFFFF);
    put_cfg(REG_WIDTH, 16'd0);
    put_cfg(REG_HEIGHT, 16'd0);
    put_item(REQ_PIXEL, 17'd65535);
    put_typed(REQ_PIXEL, 17'd7, 17'd32767, 1'b1);
    put_typed(REQ_DRAIN, 17'd0, 17'd3, 1'b1);
    // 3x3 frame with one interior pixel, then four drain items in the middle of the next frame
    put_cfg(REG_MODE, MODE_BLUR);
    put_cfg(REG_MAXV, 16'd255);
    put_cfg(REG_WIDTH, 16'd3);
    put_cfg(REG_HEIGHT, 16'd3);
    put_item(REQ_PIXEL, 17'd200);
    put_item(REQ_PIXEL, 17'd10);
    put_item(REQ_PIXEL, 17'd255);
    put_item(REQ_PIXEL, 17'd30);
    put_item(REQ_PIXEL, 17'd77);
    put_item(REQ_PIXEL, 17'd254);
    put_item(REQ_PIXEL, 17'd300);
    put_item(REQ_PIXEL, 17'd4);
    put_item(REQ_PIXEL, 17'd90);
    put_item(REQ_PIXEL, 17'd12);
    put_item(REQ_PIXEL, 17'd0);
    put_item(REQ_DRAIN, 17'd0);
    put_item(REQ_DRAIN, 17'd0);
    put_item(REQ_DRAIN, 17'd0);
    put_item(REQ_DRAIN, 17'd0);

    foreach (plan[i]) begin
      case (plan[i].kind)
        STEP_CFG: begin
          if (i == 0 || plan[i-1].kind != STEP_CFG) wait_quiet();
          write_reg(plan[i].idx, plan[i].data);
        end
        STEP_ITEM:  send(plan[i].req, plan[i].pix, 1'b0, '0);
        default:    send(plan[i].req, plan[i].pix, 1'b1, plan[i].want);
      endcase
    end

    // random frames, mostly small geometry
    while (rand_done < RAND_ITEMS) begin
      junk = $urandom;
      mode_data = {($urandom_range(0, 2) == 0) ? junk[13:0] : 14'd0,
                   2'($urandom_range(0, 3))};
      case ($urandom_range(0, 5))
        0:       max_data = 16'd0;
        1:       max_data = 16'hFFFF;
        2:       max_data = 16'd255;
        3:       max_data = $urandom_range(1, 20);
        default: max_data = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 2);
        1:       w = $urandom_range(11, 40);
        default: w = $urandom_range(3, 10);
      endcase
      case ($urandom_range(0, 7))
        0:       h = $urandom_range(0, 2);
        1:       h = $urandom_range(9, 2047);
        default: h = $urandom_range(3, 8);
      endcase
      junk = $urandom;
      w_data = {($urandom_range(0, 3) == 0) ? junk[4:0] : 5'd0, w[10:0]};
      junk = $urandom;
      h_data = {($urandom_range(0, 3) == 0) ? junk[4:0] : 5'd0, h[10:0]};
      configure(mode_data, max_data, w_data, h_data);
      calm = ($urandom_range(0, 4) == 0);
      rx_period = $urandom_range(2, 9);
      rx_stall  = $urandom_range(1, rx_period - 1);
      n = $urandom_range(30, 160);
      repeat (n) begin
        if ($urandom_range(0, 19) == 0) send(REQ_DRAIN, rand_pixel(), 1'b0, '0);
        else send(REQ_PIXEL, rand_pixel(), 1'b0, '0);
        if ($urandom_range(0, 199) == 0) wait_quiet();
      end
      flush_held();
      if ($urandom_range(0, 3) == 0) send(REQ_DRAIN, '0, 1'b0, '0);
      rand_done += n;
    end

    // widest rows: past two full rows so interior pixels get blurred
    configure({14'd0, MODE_BLUR}, 16'hFFFF, 16'h07FF, 16'd3);
    calm = 1'b0;
    repeat (2 * COLS_MAX + 40) send(REQ_PIXEL, rand_pixel(), 1'b0, '0);
    flush_held();

    wait_quiet();
    if (bad_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
